// ===== rtl/mlfqs_pkg.sv =====
// Shared types and constants for the multilevel feedback queue scheduler.
// Depends on nothing; the other files, save the queue memory, refer to it by scoped names.
`default_nettype none

package mlfqs_pkg;

    // Default geometry, handed to the top level as parameter defaults.
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int PID_BITS_DEF    = 8;
    localparam int LEVELS_DEF      = 4;

    // Number of quantum registers; deeper levels share the last one.
    localparam int NUM_QUANTA = 4;

    // Reset values of the quantum registers.
    localparam logic [7:0] QUANTUM_L1_RST = 8'd1;
    localparam logic [7:0] QUANTUM_L2_RST = 8'd2;
    localparam logic [7:0] QUANTUM_L3_RST = 8'd4;
    localparam logic [7:0] QUANTUM_L4_RST = 8'd8;

    // Configuration register indexes.
    localparam logic [1:0] CFG_QUANTUM_L1 = 2'd0;
    localparam logic [1:0] CFG_QUANTUM_L2 = 2'd1;
    localparam logic [1:0] CFG_QUANTUM_L3 = 2'd2;
    localparam logic [1:0] CFG_QUANTUM_L4 = 2'd3;

    // Outcome codes of a report request.
    localparam logic [1:0] OUTCOME_RUNNING    = 2'd0;
    localparam logic [1:0] OUTCOME_TERMINATED = 2'd1;
    localparam logic [1:0] OUTCOME_BLOCKED    = 2'd2;

    typedef enum logic [1:0] {
        CMD_ADMIT    = 2'd0,
        CMD_DISPATCH = 2'd1,
        CMD_REPORT   = 2'd2,
        CMD_NONE     = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        EV_ADMITTED   = 3'd0,
        EV_DISPATCHED = 3'd1,
        EV_IDLE_NONE  = 3'd2,
        EV_CONTINUED  = 3'd3,
        EV_RETIRED    = 3'd4,
        EV_REQUEUED   = 3'd5,
        EV_DROPPED    = 3'd6,
        EV_NOP        = 3'd7
    } t_event;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_POP  = 1'b1
    } t_state;

    typedef struct packed {
        t_event     event_res;
        logic       running_valid;
        logic [7:0] running_pid;
        logic [2:0] running_level;
        logic [7:0] slice_used;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/mlfqs_queue_mem.sv =====
// Queue storage for all priority levels: one write port, one registered read port.
// Depends on nothing beyond its parameters.
`default_nettype none

module mlfqs_queue_mem #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/mlfqs_ctrl.sv =====
// Scheduler control: per-level head, tail and count, the running process and the
// sequencer that drives the queue memory. Depends on mlfqs_pkg.
`default_nettype none

module mlfqs_ctrl #(
    parameter int QUEUE_DEPTH = mlfqs_pkg::QUEUE_DEPTH_DEF,
    parameter int PID_BITS    = mlfqs_pkg::PID_BITS_DEF,
    parameter int LEVELS      = mlfqs_pkg::LEVELS_DEF,
    localparam int LVL_W      = $clog2(LEVELS),
    localparam int PTR_W      = $clog2(QUEUE_DEPTH),
    localparam int ADDR_W     = LVL_W + PTR_W
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_fire,
    input  wire logic [1:0]          i_cmd,
    input  wire logic [PID_BITS-1:0] i_pid,
    input  wire logic [1:0]          i_outcome,
    input  wire logic [7:0]          i_quantum [mlfqs_pkg::NUM_QUANTA],
    output logic                     o_busy,
    output logic                     o_res_valid,
    output mlfqs_pkg::t_result       o_res,
    output logic                     o_mem_we,
    output logic [ADDR_W-1:0]        o_mem_waddr,
    output logic [PID_BITS-1:0]      o_mem_wdata,
    output logic                     o_mem_re,
    output logic [ADDR_W-1:0]        o_mem_raddr,
    input  wire logic [PID_BITS-1:0] i_mem_rdata
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(LEVELS - 1);

    mlfqs_pkg::t_state r_state, n_state;
    logic [PTR_W-1:0]    r_head  [LEVELS], n_head  [LEVELS];
    logic [PTR_W-1:0]    r_tail  [LEVELS], n_tail  [LEVELS];
    logic [CNT_W-1:0]    r_count [LEVELS], n_count [LEVELS];
    logic                r_run_valid, n_run_valid;
    logic [PID_BITS-1:0] r_run_pid, n_run_pid;
    logic [LVL_W-1:0]    r_run_level, n_run_level;
    logic [7:0]          r_slice, n_slice;

    mlfqs_pkg::t_cmd   cmd;
    mlfqs_pkg::t_event ev;
    logic              found;
    logic [LVL_W-1:0]  sel_lvl;
    logic [LVL_W-1:0]  next_lvl;
    logic [1:0]        q_idx;
    logic [7:0]        slice_inc;
    logic              quantum_hit;
    logic              retire;
    logic              start_pop;
    logic              push_en;
    logic [LVL_W-1:0]  push_lvl;
    logic [PID_BITS-1:0] push_pid;
    logic              show;
    logic [PID_BITS-1:0] show_pid;
    logic [LVL_W-1:0]  show_lvl;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    assign cmd = mlfqs_pkg::t_cmd'(i_cmd);

    // Highest non-empty level: level 1 (index 0) wins.
    always_comb begin
        found   = 1'b0;
        sel_lvl = '0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (r_count[l] != '0) begin
                found   = 1'b1;
                sel_lvl = LVL_W'(l);
            end
        end
    end

    assign slice_inc   = (r_slice == 8'hFF) ? r_slice : r_slice + 8'd1;
    assign q_idx       = (32'(r_run_level) > 32'd3) ? 2'd3 : 2'(r_run_level);
    assign quantum_hit = slice_inc >= i_quantum[q_idx];
    assign next_lvl    = (32'(r_run_level) + 32'd1 < 32'(LEVELS)) ?
                         r_run_level + 1'b1 : LVL_LAST;
    assign retire      = (i_outcome == mlfqs_pkg::OUTCOME_TERMINATED) ||
                         (i_outcome == mlfqs_pkg::OUTCOME_BLOCKED);
    assign start_pop   = (r_state == mlfqs_pkg::ST_IDLE) && i_fire &&
                         (cmd == mlfqs_pkg::CMD_DISPATCH) && !r_run_valid && found;

    // Next state.
    always_comb begin
        unique case (r_state)
            mlfqs_pkg::ST_IDLE: n_state = start_pop ? mlfqs_pkg::ST_POP : mlfqs_pkg::ST_IDLE;
            mlfqs_pkg::ST_POP:  n_state = mlfqs_pkg::ST_IDLE;
            default:            n_state = mlfqs_pkg::ST_IDLE;
        endcase
    end

    // Queue bookkeeping, running process and result.
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_run_valid = r_run_valid;
        n_run_pid   = r_run_pid;
        n_run_level = r_run_level;
        n_slice     = r_slice;
        ev          = mlfqs_pkg::EV_NOP;
        o_res_valid = 1'b0;
        o_mem_re    = 1'b0;
        push_en     = 1'b0;
        push_lvl    = '0;
        push_pid    = i_pid;
        show        = 1'b0;
        show_pid    = r_run_pid;
        show_lvl    = r_run_level;

        if (r_state == mlfqs_pkg::ST_POP) begin
            // The popped id arrives from memory in the cycle after the read.
            n_run_pid   = i_mem_rdata;
            ev          = mlfqs_pkg::EV_DISPATCHED;
            o_res_valid = 1'b1;
        end else if (i_fire) begin
            o_res_valid = 1'b1;
            unique case (cmd)
                mlfqs_pkg::CMD_ADMIT: begin
                    if (r_count[0] < CNT_FULL) begin
                        push_en = 1'b1;
                        ev      = mlfqs_pkg::EV_ADMITTED;
                    end else begin
                        ev      = mlfqs_pkg::EV_DROPPED;
                    end
                end
                mlfqs_pkg::CMD_DISPATCH: begin
                    if (!r_run_valid) begin
                        if (found) begin
                            o_mem_re           = 1'b1;
                            o_res_valid        = 1'b0;
                            n_head[sel_lvl]    = ptr_next(r_head[sel_lvl]);
                            n_count[sel_lvl]   = r_count[sel_lvl] - 1'b1;
                            n_run_valid        = 1'b1;
                            n_run_level        = sel_lvl;
                            n_slice            = '0;
                        end else begin
                            ev = mlfqs_pkg::EV_IDLE_NONE;
                        end
                    end
                end
                mlfqs_pkg::CMD_REPORT: begin
                    if (r_run_valid) begin
                        if (retire) begin
                            ev          = mlfqs_pkg::EV_RETIRED;
                            show        = 1'b1;
                            n_run_valid = 1'b0;
                            n_slice     = '0;
                        end else if (quantum_hit) begin
                            show        = 1'b1;
                            show_lvl    = next_lvl;
                            push_lvl    = next_lvl;
                            push_pid    = r_run_pid;
                            n_run_level = next_lvl;
                            n_run_valid = 1'b0;
                            n_slice     = '0;
                            if (r_count[next_lvl] < CNT_FULL) begin
                                push_en = 1'b1;
                                ev      = mlfqs_pkg::EV_REQUEUED;
                            end else begin
                                ev      = mlfqs_pkg::EV_DROPPED;
                            end
                        end else begin
                            ev      = mlfqs_pkg::EV_CONTINUED;
                            n_slice = slice_inc;
                        end
                    end
                end
                mlfqs_pkg::CMD_NONE: begin
                    ev = mlfqs_pkg::EV_NOP;
                end
                default: begin
                    ev = mlfqs_pkg::EV_NOP;
                end
            endcase
        end

        if (push_en) begin
            n_tail[push_lvl]  = ptr_next(r_tail[push_lvl]);
            n_count[push_lvl] = r_count[push_lvl] + 1'b1;
        end

        o_res.event_res     = ev;
        o_res.running_valid = n_run_valid;
        if (n_run_valid) begin
            o_res.running_pid   = 8'(n_run_pid);
            o_res.running_level = 3'(32'(n_run_level) + 32'd1);
            o_res.slice_used    = n_slice;
        end else if (show) begin
            o_res.running_pid   = 8'(show_pid);
            o_res.running_level = 3'(32'(show_lvl) + 32'd1);
            o_res.slice_used    = '0;
        end else begin
            o_res.running_pid   = '0;
            o_res.running_level = 3'd1;
            o_res.slice_used    = '0;
        end
    end

    assign o_mem_we    = push_en;
    assign o_mem_waddr = {push_lvl, r_tail[push_lvl]};
    assign o_mem_wdata = push_pid;
    assign o_mem_raddr = {sel_lvl, r_head[sel_lvl]};
    assign o_busy      = (r_state != mlfqs_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mlfqs_pkg::ST_IDLE;
            r_run_valid <= 1'b0;
            r_run_pid   <= '0;
            r_run_level <= '0;
            r_slice     <= '0;
            for (int l = 0; l < LEVELS; l++) begin
                r_head[l]  <= '0;
                r_tail[l]  <= '0;
                r_count[l] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_run_valid <= n_run_valid;
            r_run_pid   <= n_run_pid;
            r_run_level <= n_run_level;
            r_slice     <= n_slice;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
        end
    end

    a_pop_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mlfqs_pkg::ST_POP |=> r_state == mlfqs_pkg::ST_IDLE)
        else $error("pop state held longer than one cycle");

    a_pop_has_runner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mlfqs_pkg::ST_POP |-> r_run_valid && o_res_valid)
        else $error("pop completion without a running process or result");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem_we && o_mem_re))
        else $error("queue push and pop issued for the same request");

    a_request_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && !o_busy && !o_res_valid |=> r_state == mlfqs_pkg::ST_POP)
        else $error("request accepted without a result or a pending pop");

endmodule

`default_nettype wire

// ===== rtl/mlfqs_out_buf.sv =====
// Two-entry output buffer (result register plus skid entry) for scheduler results.
// Depends on mlfqs_pkg for the result type.
`default_nettype none

module mlfqs_out_buf (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  mlfqs_pkg::t_result      i_data,
    output logic                    o_room,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output mlfqs_pkg::t_result      o_data
);

    logic               r_out_valid, n_out_valid;
    logic               r_skid_valid, n_skid_valid;
    mlfqs_pkg::t_result r_out, n_out;
    mlfqs_pkg::t_result r_skid, n_skid;
    logic               out_take;

    assign out_take = r_out_valid && i_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = i_push;
                n_skid       = i_data;
            end else begin
                n_out_valid  = i_push;
                n_out        = i_data;
            end
        end else if (i_push) begin
            n_skid_valid = 1'b1;
            n_skid       = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_room  = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while the result register is empty");

endmodule

`default_nettype wire

// ===== rtl/mlfq_process_scheduler.sv =====
// Top level of the four-level multilevel feedback queue scheduler.
// Depends on mlfqs_pkg, mlfqs_queue_mem, mlfqs_ctrl and mlfqs_out_buf.
//
// Use of the block:
// - Request channel (i_in_valid / o_in_ready) carries i_cmd, i_new_pid and i_outcome.
//   An admit appends the id to level 1, a dispatch starts the head of the highest
//   non-empty level when nothing runs, and a report accounts one instruction of the
//   running process, retiring or demoting it as its outcome and quantum dictate.
// - Result channel (o_out_valid / i_out_ready) returns exactly one result per request,
//   in request order.
// - Configuration channel (i_cfg_valid / o_cfg_ready) writes the four quantum
//   registers; it is always ready and should be used only while the block is idle.
// Flow: admits, reports and dispatches that find nothing to start are answered when
// they are taken, and their result is registered in the output buffer. A dispatch that
// pops a queue first reads the queue memory and delivers its result from the pop state,
// when the registered read returns the id; no request is taken until that state ends.
// Reset (synchronous, active low) empties every queue, stops the running process and
// restores the quantum registers to 1, 2, 4 and 8. The queue memory is not cleared:
// the head, tail and count registers guarantee that no entry is read before written.
// When the receiver stalls, one further result is parked in a skid entry; requests are
// refused once that entry is occupied too, and while a pop is in progress.
`default_nettype none

module mlfq_process_scheduler #(
    parameter int QUEUE_DEPTH = mlfqs_pkg::QUEUE_DEPTH_DEF,
    parameter int PID_BITS    = mlfqs_pkg::PID_BITS_DEF,
    parameter int LEVELS      = mlfqs_pkg::LEVELS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // request channel
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_cmd,
    input  wire logic [7:0] i_new_pid,
    input  wire logic [1:0] i_outcome,
    // result channel
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [2:0]      o_event_res,
    output logic            o_running_valid,
    output logic [7:0]      o_running_pid,
    output logic [2:0]      o_running_level,
    output logic [7:0]      o_slice_used,
    // configuration channel
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);

    localparam int LVL_W  = $clog2(LEVELS);
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int ADDR_W = LVL_W + PTR_W;

    // Quantum registers, one per level; levels beyond the fourth use the last.
    logic [7:0] r_quantum [mlfqs_pkg::NUM_QUANTA];

    logic                in_fire;
    logic                busy;
    logic                res_valid;
    mlfqs_pkg::t_result  res;
    mlfqs_pkg::t_result  out_data;
    logic                room;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [PID_BITS-1:0] mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [PID_BITS-1:0] mem_rdata;

    // A request is taken only between pops and while the output side can hold its result.
    assign o_in_ready  = !busy && room;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum[0] <= mlfqs_pkg::QUANTUM_L1_RST;
            r_quantum[1] <= mlfqs_pkg::QUANTUM_L2_RST;
            r_quantum[2] <= mlfqs_pkg::QUANTUM_L3_RST;
            r_quantum[3] <= mlfqs_pkg::QUANTUM_L4_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                mlfqs_pkg::CFG_QUANTUM_L1: r_quantum[0] <= i_cfg_data;
                mlfqs_pkg::CFG_QUANTUM_L2: r_quantum[1] <= i_cfg_data;
                mlfqs_pkg::CFG_QUANTUM_L3: r_quantum[2] <= i_cfg_data;
                mlfqs_pkg::CFG_QUANTUM_L4: r_quantum[3] <= i_cfg_data;
                default:                   r_quantum[3] <= i_cfg_data;
            endcase
        end
    end

    mlfqs_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PID_BITS    (PID_BITS),
        .LEVELS      (LEVELS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (in_fire),
        .i_cmd       (i_cmd),
        .i_pid       (PID_BITS'(i_new_pid)),
        .i_outcome   (i_outcome),
        .i_quantum   (r_quantum),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    // All levels share one memory; the level index forms the upper address bits.
    mlfqs_queue_mem #(
        .ADDR_W (ADDR_W),
        .DATA_W (PID_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    mlfqs_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_data)
    );

    assign o_event_res     = out_data.event_res;
    assign o_running_valid = out_data.running_valid;
    assign o_running_pid   = out_data.running_pid;
    assign o_running_level = out_data.running_level;
    assign o_slice_used    = out_data.slice_used;

endmodule

`default_nettype wire
